// ===== src/stereo_fade_gain_ramp_core_assert.svh =====
// assertion macros for the stereo fade gain ramp datapath
// needs clk and rst_n in the including module's scope
`ifndef STEREO_FADE_GAIN_RAMP_CORE_ASSERT_SVH
`define STEREO_FADE_GAIN_RAMP_CORE_ASSERT_SVH

// consequent checked in the same cycle
`define SFG_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfg assertion failed");

// consequent checked in the cycle after the antecedent
`define SFG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfg assertion failed");

`endif

// ===== src/sfg_pkg.sv =====
// shared types and constants for the stereo fade gain ramp block
// no dependencies
`timescale 1ns / 1ps

package sfg_pkg;

    localparam int SMP_W   = 16;
    localparam int DUR_W   = 15;
    localparam int RATE_W  = 16;
    localparam int LEVEL_W = 25;
    localparam int STEP_W  = 32;
    localparam int GAIN_W  = 16;
    localparam int PROD_W  = 31;
    localparam int DIVR_W  = 26;
    localparam int QUO_W   = 31;
    localparam int CNT_W   = 5;

    localparam logic [LEVEL_W-1:0]   LEVEL_MAX    = 25'h1FF_FFFF;
    localparam logic [QUO_W-1:0]     STEP_NUM     = 31'h4000_0000;
    localparam logic [RATE_W-1:0]    RATE_RESET   = 16'd44100;
    localparam logic signed [12:0]   DECAY_MUL    = 13'sh0F00;
    localparam logic [CNT_W-1:0]     DIV_TOP_BIT  = 5'd30;

    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_UNDERRUN = 2'd1,
        OP_FADE     = 2'd2,
        OP_FLUSH    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAMP,
        S_FADE,
        S_EMIT,
        S_MULD,
        S_DSET,
        S_DIV,
        S_DEND
    } state_t;

    typedef enum logic [1:0] {
        GM_PASS,
        GM_MUTE,
        GM_RAMP
    } gain_mode_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic samp;
        logic fade;
        logic emit;
        logic mul_rate;
        logic div_init;
        logic div_step;
        logic step_wr;
    } ctrl_cmd_t;

    typedef struct packed {
        logic dur_zero;
        logic div_zero;
        logic div_last;
        logic out_free;
    } dp_status_t;

endpackage

// ===== src/sfg_in_if.sv =====
// input channel of the stereo fade gain ramp block: valid/ready plus item fields
// no dependencies
`timescale 1ns / 1ps

interface sfg_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
    logic signed [14:0] fade_duration;

    modport source (output valid, output op, output left_in, output right_in,
                    output fade_duration, input ready);
    modport sink (input valid, input op, input left_in, input right_in,
                  input fade_duration, output ready);
endinterface

// ===== src/sfg_out_if.sv =====
// result channel of the stereo fade gain ramp block: valid/ready plus item fields
// no dependencies
`timescale 1ns / 1ps

interface sfg_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic              fading;

    modport source (output valid, output left_out, output right_out, output fading,
                    input ready);
    modport sink (input valid, input left_out, input right_out, input fading,
                  output ready);
endinterface

// ===== src/sfg_ctrl.sv =====
// controller state machine of the stereo fade gain ramp block
// depends on sfg_pkg
`timescale 1ns / 1ps

module sfg_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             in_op,
    output logic                   in_ready,
    input  sfg_pkg::dp_status_t    sts,
    output sfg_pkg::ctrl_cmd_t     cmd
);

    sfg_pkg::state_t state_reg;
    sfg_pkg::state_t state_next;
    sfg_pkg::op_t    op_sel;

    assign op_sel = sfg_pkg::op_t'(in_op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sfg_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sfg_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (op_sel inside {sfg_pkg::OP_SAMPLE, sfg_pkg::OP_UNDERRUN})
                    begin
                        state_next = sfg_pkg::S_SAMP;
                    end
                    else if (op_sel == sfg_pkg::OP_FADE)
                    begin
                        state_next = sfg_pkg::S_MULD;
                    end
                    else
                    begin
                        cmd.clear = 1'b1;
                    end
                end
            end
            sfg_pkg::S_SAMP:
            begin
                cmd.samp   = 1'b1;
                state_next = sfg_pkg::S_FADE;
            end
            sfg_pkg::S_FADE:
            begin
                cmd.fade   = 1'b1;
                state_next = sfg_pkg::S_EMIT;
            end
            sfg_pkg::S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sfg_pkg::S_IDLE;
                end
            end
            sfg_pkg::S_MULD:
            begin
                // zero duration leaves the ramp untouched
                if (sts.dur_zero)
                begin
                    state_next = sfg_pkg::S_IDLE;
                end
                else
                begin
                    cmd.mul_rate = 1'b1;
                    state_next   = sfg_pkg::S_DSET;
                end
            end
            sfg_pkg::S_DSET:
            begin
                cmd.div_init = 1'b1;
                state_next   = sfg_pkg::S_DIV;
            end
            sfg_pkg::S_DIV:
            begin
                // zero divisor keeps the full-scale numerator as the step
                if (sts.div_zero)
                begin
                    state_next = sfg_pkg::S_DEND;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_last)
                    begin
                        state_next = sfg_pkg::S_DEND;
                    end
                end
            end
            sfg_pkg::S_DEND:
            begin
                cmd.step_wr = 1'b1;
                state_next  = sfg_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sfg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/sfg_dp.sv =====
// datapath of the stereo fade gain ramp block: gain state, multipliers, divider
// depends on sfg_pkg and stereo_fade_gain_ramp_core_assert.svh
`timescale 1ns / 1ps

`include "stereo_fade_gain_ramp_core_assert.svh"

module sfg_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sfg_pkg::ctrl_cmd_t          cmd,
    output sfg_pkg::dp_status_t         sts,
    input  logic                        cfg_we,
    input  logic [sfg_pkg::RATE_W-1:0]  cfg_wdata,
    input  logic [1:0]                  in_op,
    input  logic signed [sfg_pkg::SMP_W-1:0] in_left,
    input  logic signed [sfg_pkg::SMP_W-1:0] in_right,
    input  logic signed [sfg_pkg::DUR_W-1:0] in_dur,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [sfg_pkg::SMP_W-1:0] out_left,
    output logic signed [sfg_pkg::SMP_W-1:0] out_right,
    output logic                        out_fading
);

    // control and architectural state
    logic [sfg_pkg::RATE_W-1:0]         rate_reg;
    logic [sfg_pkg::LEVEL_W-1:0]        level_reg;
    logic [sfg_pkg::LEVEL_W-1:0]        level_next;
    logic [sfg_pkg::STEP_W-1:0]         step_reg;
    logic [sfg_pkg::STEP_W-1:0]         step_next;
    logic                               active_reg;
    logic                               active_next;
    logic signed [sfg_pkg::SMP_W-1:0]   held_l_reg;
    logic signed [sfg_pkg::SMP_W-1:0]   held_r_reg;
    logic                               out_valid_reg;

    // payload registers
    sfg_pkg::op_t                       op_reg;
    logic signed [sfg_pkg::SMP_W-1:0]   l_in_reg;
    logic signed [sfg_pkg::SMP_W-1:0]   r_in_reg;
    logic signed [sfg_pkg::DUR_W-1:0]   dur_reg;
    logic signed [sfg_pkg::SMP_W-1:0]   smp_l_reg;
    logic signed [sfg_pkg::SMP_W-1:0]   smp_r_reg;
    logic signed [sfg_pkg::SMP_W-1:0]   prod_l_reg;
    logic signed [sfg_pkg::SMP_W-1:0]   prod_r_reg;
    sfg_pkg::gain_mode_t                mode_reg;
    sfg_pkg::gain_mode_t                mode_next;
    logic [sfg_pkg::PROD_W-1:0]         p_reg;
    logic                               neg_reg;
    logic [sfg_pkg::DIVR_W-1:0]         d_reg;
    logic [sfg_pkg::DIVR_W-1:0]         rem_reg;
    logic [sfg_pkg::QUO_W-1:0]          quo_reg;
    logic [sfg_pkg::CNT_W-1:0]          cnt_reg;
    logic signed [sfg_pkg::SMP_W-1:0]   out_l_reg;
    logic signed [sfg_pkg::SMP_W-1:0]   out_r_reg;
    logic                               out_fading_reg;

    // combinational datapath
    logic signed [28:0]                 dec_l_prod;
    logic signed [28:0]                 dec_r_prod;
    logic signed [sfg_pkg::SMP_W-1:0]   smp_l_next;
    logic signed [sfg_pkg::SMP_W-1:0]   smp_r_next;
    logic [sfg_pkg::GAIN_W-1:0]         gain;
    logic signed [32:0]                 mul_l;
    logic signed [32:0]                 mul_r;
    logic signed [33:0]                 lvl_sum;
    logic                               clamp_lo;
    logic                               clamp_hi;
    logic [sfg_pkg::DUR_W-1:0]          dur_mag;
    logic [sfg_pkg::PROD_W-1:0]         rate_prod;
    logic [31:0]                        p_round;
    logic [sfg_pkg::DIVR_W-1:0]         d_next;
    logic [sfg_pkg::DIVR_W:0]           trial;
    logic                               ge;
    logic [sfg_pkg::DIVR_W:0]           trial_sub;
    logic [sfg_pkg::STEP_W-1:0]         q_ext;
    logic signed [sfg_pkg::SMP_W-1:0]   emit_l;
    logic signed [sfg_pkg::SMP_W-1:0]   emit_r;

    // underrun decay by 15/16 with floor rounding
    assign dec_l_prod = held_l_reg * sfg_pkg::DECAY_MUL;
    assign dec_r_prod = held_r_reg * sfg_pkg::DECAY_MUL;
    assign smp_l_next = (op_reg == sfg_pkg::OP_UNDERRUN) ? dec_l_prod[27:12] : l_in_reg;
    assign smp_r_next = (op_reg == sfg_pkg::OP_UNDERRUN) ? dec_r_prod[27:12] : r_in_reg;

    // fade multiply, floor shift by 16 keeps the upper bits
    assign gain  = level_reg[sfg_pkg::LEVEL_W-1:9];
    assign mul_l = smp_l_reg * $signed({1'b0, gain});
    assign mul_r = smp_r_reg * $signed({1'b0, gain});

    always_comb
    begin
        if (rate_reg == '0)
        begin
            mode_next = sfg_pkg::GM_PASS;
        end
        else if (!active_reg)
        begin
            mode_next = (level_reg == '0) ? sfg_pkg::GM_MUTE : sfg_pkg::GM_PASS;
        end
        else
        begin
            mode_next = sfg_pkg::GM_RAMP;
        end
    end

    // level update, clamping only when the step overshoots a limit
    assign lvl_sum  = $signed({9'b0, level_reg}) + $signed({{2{step_reg[31]}}, step_reg});
    assign clamp_lo = step_reg[31] && lvl_sum[33];
    assign clamp_hi = !step_reg[31] && (lvl_sum > $signed({9'b0, sfg_pkg::LEVEL_MAX}));

    // divisor: rate * |ms| / 32, rounded toward minus infinity for fade-out
    assign dur_mag   = dur_reg[sfg_pkg::DUR_W-1] ? 15'(-dur_reg) : 15'(dur_reg);
    assign rate_prod = rate_reg * dur_mag;
    assign p_round   = {1'b0, p_reg} + 32'd31;
    assign d_next    = neg_reg ? p_round[30:5] : p_reg[30:5];

    // one restoring division bit per cycle
    assign trial     = {rem_reg, quo_reg[sfg_pkg::QUO_W-1]};
    assign ge        = trial >= {1'b0, d_reg};
    assign trial_sub = trial - {1'b0, d_reg};
    assign q_ext     = {1'b0, quo_reg};

    always_comb
    begin
        level_next  = level_reg;
        step_next   = step_reg;
        active_next = active_reg;
        if (cmd.clear)
        begin
            level_next  = '0;
            step_next   = '0;
            active_next = 1'b0;
        end
        else if (cmd.step_wr)
        begin
            step_next   = neg_reg ? 32'(-q_ext) : q_ext;
            active_next = 1'b1;
        end
        else if (cmd.fade && mode_next == sfg_pkg::GM_RAMP)
        begin
            if (clamp_lo)
            begin
                level_next  = '0;
                step_next   = '0;
                active_next = 1'b0;
            end
            else if (clamp_hi)
            begin
                level_next  = sfg_pkg::LEVEL_MAX;
                step_next   = '0;
                active_next = 1'b0;
            end
            else
            begin
                level_next = lvl_sum[sfg_pkg::LEVEL_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (mode_reg)
            sfg_pkg::GM_RAMP:
            begin
                emit_l = prod_l_reg;
                emit_r = prod_r_reg;
            end
            sfg_pkg::GM_MUTE:
            begin
                emit_l = '0;
                emit_r = '0;
            end
            default:
            begin
                emit_l = smp_l_reg;
                emit_r = smp_r_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= sfg_pkg::RATE_RESET;
            level_reg     <= '0;
            step_reg      <= '0;
            active_reg    <= 1'b0;
            held_l_reg    <= '0;
            held_r_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                rate_reg <= cfg_wdata;
            end
            level_reg  <= level_next;
            step_reg   <= step_next;
            active_reg <= active_next;
            if (cmd.clear)
            begin
                held_l_reg <= '0;
                held_r_reg <= '0;
            end
            else if (cmd.samp)
            begin
                held_l_reg <= smp_l_next;
                held_r_reg <= smp_r_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= sfg_pkg::op_t'(in_op);
            l_in_reg <= in_left;
            r_in_reg <= in_right;
            dur_reg  <= in_dur;
        end
        if (cmd.samp)
        begin
            smp_l_reg <= smp_l_next;
            smp_r_reg <= smp_r_next;
        end
        if (cmd.fade)
        begin
            prod_l_reg <= mul_l[31:16];
            prod_r_reg <= mul_r[31:16];
            mode_reg   <= mode_next;
        end
        if (cmd.mul_rate)
        begin
            p_reg   <= rate_prod;
            neg_reg <= dur_reg[sfg_pkg::DUR_W-1];
        end
        if (cmd.div_init)
        begin
            d_reg   <= d_next;
            rem_reg <= '0;
            quo_reg <= sfg_pkg::STEP_NUM;
            cnt_reg <= sfg_pkg::DIV_TOP_BIT;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? trial_sub[sfg_pkg::DIVR_W-1:0] : trial[sfg_pkg::DIVR_W-1:0];
            quo_reg <= {quo_reg[sfg_pkg::QUO_W-2:0], ge};
            cnt_reg <= cnt_reg - 5'd1;
        end
        if (cmd.emit)
        begin
            out_l_reg      <= emit_l;
            out_r_reg      <= emit_r;
            out_fading_reg <= active_reg;
        end
    end

    assign sts.dur_zero = (dur_reg == '0);
    assign sts.div_zero = (d_reg == '0);
    assign sts.div_last = (cnt_reg == '0);
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_left   = out_l_reg;
    assign out_right  = out_r_reg;
    assign out_fading = out_fading_reg;

    `SFG_ASSERT_SAME(a_idle_step_zero, !active_reg, step_reg == '0)
    `SFG_ASSERT_NEXT(a_held_only_on_item, !cmd.samp && !cmd.clear, $stable(held_l_reg) && $stable(held_r_reg))
    `SFG_ASSERT_SAME(a_emit_slot_free, cmd.emit, !out_valid_reg || out_ready)
    `SFG_ASSERT_SAME(a_div_nonzero, cmd.div_step, d_reg != '0)

endmodule

// ===== src/stereo_fade_gain_ramp_core.sv =====
// top level of the stereo fade gain ramp block: controller plus datapath
// depends on sfg_pkg, sfg_in_if, sfg_out_if, sfg_ctrl and sfg_dp
//
// usage:
//   samples  - input items: op (sample, underrun fill, start fade, flush), left and
//              right samples, signed fade duration in ms
//   results  - one output item per sample or underrun item: faded left and right
//              samples plus the fading flag; start fade and flush give none
//   cfg_we / cfg_wdata - write of the sample rate register, only while idle
// sequence:
//   sample and underrun items: after the item is taken, the sample, fade and emit
//   states run in turn; the next item is taken once the block is back in idle
//   start fade: busy through the multiply, the 31-step shift/subtract divider that
//   forms the per-sample step, and the step write; with a zero divisor no step runs;
//   zero duration returns to idle from the multiply state, step untouched
//   flush: done in the cycle it is taken
// reset: rate 44100 Hz, level zero so output is muted until a fade in,
//   no ramp running, held sample zero
// stall: a result waits in the output register; the next item is taken
//   meanwhile, and only the following result waits for that register to drain
`timescale 1ns / 1ps

module stereo_fade_gain_ramp_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [sfg_pkg::RATE_W-1:0] cfg_wdata,
    sfg_in_if.sink                     samples,
    sfg_out_if.source                  results
);

    sfg_pkg::ctrl_cmd_t  cmd;
    sfg_pkg::dp_status_t sts;

    sfg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_op    (samples.op),
        .in_ready (samples.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sfg_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_op      (samples.op),
        .in_left    (samples.left_in),
        .in_right   (samples.right_in),
        .in_dur     (samples.fade_duration),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .out_left   (results.left_out),
        .out_right  (results.right_out),
        .out_fading (results.fading)
    );

endmodule

// ===== sim/tb_top.sv =====
// self-checking bench for stereo_fade_gain_ramp_core: directed table then random fade sequences
// depends on sfg_pkg, sfg_in_if, sfg_out_if and the core rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int  SETTLE_CYC = 40;
    localparam int  PHASE_ITEMS = 165;
    localparam time TIMEOUT_NS = 2_000_000;

    typedef struct packed {
        sfg_pkg::op_t       op;
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [14:0] dur;
    } audio_item_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               fading;
    } faded_smp_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_RATE
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        audio_item_t it;
        logic [15:0] rate;
        bit          chk;
        faded_smp_t  want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    sfg_in_if  samples_if ();
    sfg_out_if results_if ();

    stereo_fade_gain_ramp_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .samples   (samples_if),
        .results   (results_if)
    );

    always #1 clk = ~clk;

    // shadow of the fade state
    logic [sfg_pkg::RATE_W-1:0]  ramp_rate = sfg_pkg::RATE_RESET;
    logic [sfg_pkg::LEVEL_W-1:0] ramp_level = '0;
    logic signed [31:0] ramp_step = '0;
    bit                 ramp_running = 1'b0;
    logic signed [15:0] held_left = '0;
    logic signed [15:0] held_right = '0;

    faded_smp_t faded_pending[$];
    dir_row_t   dir_rows[$];
    bit         failed = 1'b0;
    bit         no_idle = 1'b0;

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic audio_item_t rand_item(input sfg_pkg::op_t op);
        audio_item_t it;
        it.op = op;
        it.left = 16'($urandom);
        it.right = 16'($urandom);
        it.dur = 15'($urandom);
        return it;
    endfunction

    function automatic dir_row_t item_row(input sfg_pkg::op_t op, input int l, input int r,
                                          input int d,
                                          input bit chk = 1'b0, input int el = 0,
                                          input int er = 0, input bit ef = 1'b0);
        dir_row_t row;
        row.kind = ROW_ITEM;
        row.it.op = op;
        row.it.left = l[15:0];
        row.it.right = r[15:0];
        row.it.dur = d[14:0];
        row.rate = '0;
        row.chk = chk;
        row.want.left = el[15:0];
        row.want.right = er[15:0];
        row.want.fading = ef;
        return row;
    endfunction

    function automatic dir_row_t rate_row(input int v);
        dir_row_t row;
        row = item_row(sfg_pkg::OP_SAMPLE, 0, 0, 0);
        row.kind = ROW_RATE;
        row.rate = v[15:0];
        return row;
    endfunction

    // next fade state for one accepted item, plus the output sample if it makes one
    task automatic apply_fade_item(input audio_item_t it, output bit has_res,
                                   output faded_smp_t res);
        longint l, r, g, rt, d, dv, q, st, nxt;
        has_res = 1'b0;
        res = '0;
        case (it.op)
            sfg_pkg::OP_FADE:
            begin
                if (it.dur != 0)
                begin
                    rt = longint'(ramp_rate);
                    d = longint'(it.dur);
                    dv = (rt * d) >>> 5;
                    if (dv == 0)
                        q = (d > 0) ? 64'sd1073741824 : -64'sd1073741824;
                    else
                        q = 64'sd1073741824 / dv;
                    ramp_step = q[31:0];
                    ramp_running = 1'b1;
                end
            end
            sfg_pkg::OP_FLUSH:
            begin
                ramp_level = '0;
                ramp_step = '0;
                ramp_running = 1'b0;
                held_left = '0;
                held_right = '0;
            end
            default:
            begin
                if (it.op == sfg_pkg::OP_SAMPLE)
                begin
                    l = longint'(it.left);
                    r = longint'(it.right);
                end
                else
                begin
                    l = longint'(held_left);
                    r = longint'(held_right);
                    l = (l * longint'(sfg_pkg::DECAY_MUL)) >>> 12;
                    r = (r * longint'(sfg_pkg::DECAY_MUL)) >>> 12;
                end
                held_left = l[15:0];
                held_right = r[15:0];
                // rate zero freezes everything and passes the sample through
                if (ramp_rate != 0)
                begin
                    if (!ramp_running)
                    begin
                        if (ramp_level == 0)
                        begin
                            l = 0;
                            r = 0;
                        end
                    end
                    else
                    begin
                        g = longint'(ramp_level) >> 9;
                        l = (l * g) >>> 16;
                        r = (r * g) >>> 16;
                        st = longint'(ramp_step);
                        nxt = longint'(ramp_level) + st;
                        // landing exactly on a limit keeps the ramp going
                        if (st < 0)
                        begin
                            if (nxt < 0)
                            begin
                                nxt = 0;
                                ramp_step = '0;
                                ramp_running = 1'b0;
                            end
                        end
                        else if (nxt > longint'(sfg_pkg::LEVEL_MAX))
                        begin
                            nxt = longint'(sfg_pkg::LEVEL_MAX);
                            ramp_step = '0;
                            ramp_running = 1'b0;
                        end
                        ramp_level = nxt[sfg_pkg::LEVEL_W-1:0];
                    end
                end
                res.left = l[15:0];
                res.right = r[15:0];
                res.fading = ramp_running;
                has_res = 1'b1;
            end
        endcase
    endtask

    task automatic push_item(input audio_item_t it, input bit chk, input faded_smp_t typed);
        int unsigned gap;
        bit          has_res;
        faded_smp_t  res;
        gap = draw_gap();
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid <= 1'b1;
        samples_if.op <= it.op;
        samples_if.left_in <= it.left;
        samples_if.right_in <= it.right;
        samples_if.fade_duration <= it.dur;
        do @(posedge clk); while (!samples_if.ready);
        apply_fade_item(it, has_res, res);
        if (has_res)
            faded_pending.push_back(chk ? typed : res);
    endtask

    // rate writes only once the block has drained, fade commands leave no result behind
    task automatic write_rate(input logic [15:0] v);
        samples_if.valid <= 1'b0;
        while (faded_pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        ramp_rate = v;
    endtask

    // runs of samples, each usually opened by a fade command, now and then a flush first
    task automatic run_phase(input int n);
        audio_item_t it;
        faded_smp_t  none;
        int          sent;
        int          run;
        int          k;
        int          mag;
        none = '0;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(0, 15) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 9) == 0)
            begin
                push_item(rand_item(sfg_pkg::OP_FLUSH), 1'b0, none);
                sent++;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                it = rand_item(sfg_pkg::OP_FADE);
                k = $urandom_range(0, 9);
                if (k < 6)
                    mag = $urandom_range(1, 2);
                else if (k < 8)
                    mag = $urandom_range(3, 64);
                else
                    mag = 0;
                if (mag > 0)
                    it.dur = $urandom_range(0, 1) ? 15'(mag) : 15'(-mag);
                push_item(it, 1'b0, none);
                sent++;
            end
            run = $urandom_range(0, 48);
            repeat (run)
            begin
                k = $urandom_range(0, 99);
                if (k < 80)
                    it = rand_item(sfg_pkg::OP_SAMPLE);
                else if (k < 95)
                    it = rand_item(sfg_pkg::OP_UNDERRUN);
                else
                    it = rand_item(sfg_pkg::op_t'($urandom_range(0, 3)));
                push_item(it, 1'b0, none);
                sent++;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic signed [31:0] expv,
                                   input logic signed [31:0] actv);
        failed = 1'b1;
        $display("%0t: %s expected %0d actual %0d", $time, what, expv, actv);
    endtask

    faded_smp_t want;

    always @(posedge clk)
    begin
        if (rst_n && results_if.valid && results_if.ready)
        begin
            if (faded_pending.size() == 0)
            begin
                failed = 1'b1;
                $display("%0t: result with no item pending: %0d %0d %0d", $time,
                         results_if.left_out, results_if.right_out, results_if.fading);
            end
            else
            begin
                want = faded_pending.pop_front();
                if (results_if.left_out !== want.left)
                    report_mismatch("left_out", want.left, results_if.left_out);
                if (results_if.right_out !== want.right)
                    report_mismatch("right_out", want.right, results_if.right_out);
                if (results_if.fading !== want.fading)
                    report_mismatch("fading", want.fading, results_if.fading);
            end
        end
    end

    initial
    begin : result_sink
        int unsigned stall;
        results_if.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do @(posedge clk); while (!results_if.valid);
        end
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        int rates[10];
        samples_if.valid <= 1'b0;
        samples_if.op <= sfg_pkg::OP_SAMPLE;
        samples_if.left_in <= '0;
        samples_if.right_in <= '0;
        samples_if.fade_duration <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        rst_n <= 1'b0;

        // muted after reset, level still zero
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 32767, -32768, 0, 1, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, -1, 1, 0, 1, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_UNDERRUN, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_FADE, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 100, -100, 0, 1, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_FADE, 0, 0, 1));
        // first ramp sample still sees gain zero
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 32767, -32768, 0, 1, 0, 0, 1));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 32767, -32768, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_UNDERRUN, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_FADE, 0, 0, -16384));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, -32768, 32767, 0));
        // restart while running keeps the level
        dir_rows.push_back(item_row(sfg_pkg::OP_FADE, 0, 0, 16383));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 21845, -21846, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_FLUSH, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 5, 5, 0, 1, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_UNDERRUN, 0, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(rate_row(0));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 1234, -4321, 0, 1, 1234, -4321, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_FADE, 0, 0, 5));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, -7, 7, 0, 1, -7, 7, 1));
        // step was latched at rate zero, so the ramp jumps straight to full
        dir_rows.push_back(rate_row(31));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 32767, 32767, 0, 1, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 1000, -1000, 0, 1, 1000, -1000, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_FADE, 0, 0, -1));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 32767, -32768, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, 1, 1, 0, 1, 0, 0, 0));
        // divisor rounds to zero
        dir_rows.push_back(rate_row(1));
        dir_rows.push_back(item_row(sfg_pkg::OP_FADE, 0, 0, 1));
        dir_rows.push_back(item_row(sfg_pkg::OP_UNDERRUN, 0, 0, 0));
        dir_rows.push_back(item_row(sfg_pkg::OP_SAMPLE, -32768, -32768, 0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_RATE)
                write_rate(dir_rows[i].rate);
            else
                push_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].want);
        end

        // 31744 Hz with 1 ms gives a step that lands exactly on both limits
        rates = '{44100, 31744, 0, 65535, 1, 8000, 31744, 992, 48000, 0};
        rates[9] = $urandom_range(2, 65535);
        foreach (rates[p])
        begin
            write_rate(rates[p][15:0]);
            run_phase(PHASE_ITEMS);
        end

        samples_if.valid <= 1'b0;
        while (faded_pending.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
        if (!failed)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/sfg_pkg.sv
src/sfg_in_if.sv
src/sfg_out_if.sv
src/sfg_ctrl.sv
src/sfg_dp.sv
src/stereo_fade_gain_ramp_core.sv
sim/tb_top.sv
